// ===== rtl/core/frag_reasm_pkg.sv =====
// ============================================================================
// frag_reasm_pkg
// Shared codes, widths and types of the fragment reassembler.
// ============================================================================
`default_nettype none

package frag_reasm_pkg;

    // Default size of the message store in bytes
    localparam int STORE_DEPTH_DEF = 256;

    // Field widths of one request and one result
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int MSG_LEN_W = 9;
    localparam int REM_W     = 6;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - MSG_LEN_W - BYTE_W;

    // Header byte layout
    localparam int HDR_LAST_BIT  = 7;
    localparam int HDR_FIRST_BIT = 6;

    // Commands
    localparam logic [CMD_W-1:0] CMD_HEADER  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROP_PREV = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROP_FRAG = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd6;

    // Result of one request as it leaves the control stage
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [MSG_LEN_W-1:0] length;
        logic                 is_read;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/frag_reasm_store.sv =====
// ============================================================================
// frag_reasm_store
// Message store: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module frag_reasm_store #(
    parameter int STORE_DEPTH = frag_reasm_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [AW-1:0]                     wr_addr,
    input  wire logic [frag_reasm_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                              rd_en,
    input  wire logic [AW-1:0]                     rd_addr,
    output logic      [frag_reasm_pkg::BYTE_W-1:0] rd_data
);

    logic [frag_reasm_pkg::BYTE_W-1:0] mem [STORE_DEPTH];

    // Write payload bytes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one byte, hold it until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/frag_reasm_ctrl.sv =====
// ============================================================================
// frag_reasm_ctrl
// Fragment state: decodes each request, updates offsets and lengths and
// drives the store write and read ports.
// ============================================================================
`default_nettype none

module frag_reasm_ctrl #(
    parameter int STORE_DEPTH = frag_reasm_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic [frag_reasm_pkg::CMD_W-1:0]   command,
    input  wire logic [frag_reasm_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic [frag_reasm_pkg::INDEX_W-1:0] read_index,
    output frag_reasm_pkg::result_t                 result,
    output logic                                    wr_en,
    output logic      [AW-1:0]                      wr_addr,
    output logic      [frag_reasm_pkg::BYTE_W-1:0]  wr_data,
    output logic                                    rd_en,
    output logic      [AW-1:0]                      rd_addr
);

    // Offset holds 0..STORE_DEPTH; compare width covers offset and index
    localparam int OW = $clog2(STORE_DEPTH + 1);
    localparam int CW = (OW > frag_reasm_pkg::INDEX_W) ? OW : frag_reasm_pkg::INDEX_W;
    localparam int LW = (OW > frag_reasm_pkg::MSG_LEN_W) ? OW : frag_reasm_pkg::MSG_LEN_W;

    logic [OW-1:0]                         offset_reg, offset_next;
    logic [frag_reasm_pkg::REM_W-1:0]      remain_reg, remain_next;
    logic                                  last_reg, last_next;
    logic                                  discard_reg, discard_next;
    logic [OW-1:0]                         asm_len_reg, asm_len_next;
    logic [frag_reasm_pkg::STATUS_W-1:0]   status;
    logic [CW-1:0]                         index_ext;
    logic [LW-1:0]                         len_ext;
    logic                                  first_hdr;
    logic                                  read_hit;

    assign index_ext = CW'(read_index);
    assign first_hdr = data_byte[frag_reasm_pkg::HDR_FIRST_BIT];
    assign read_hit  = (index_ext < CW'(asm_len_reg)) && (index_ext < CW'(STORE_DEPTH));

    // Decode the request and work out the next fragment state
    always_comb
    begin
        offset_next  = offset_reg;
        remain_next  = remain_reg;
        last_next    = last_reg;
        discard_next = discard_reg;
        asm_len_next = asm_len_reg;
        status       = frag_reasm_pkg::ST_NOTHING;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (command)
            frag_reasm_pkg::CMD_HEADER:
            begin
                remain_next  = data_byte[frag_reasm_pkg::REM_W-1:0];
                last_next    = data_byte[frag_reasm_pkg::HDR_LAST_BIT];
                discard_next = 1'b0;
                // First flag disagrees with position: drop message or fragment
                if (first_hdr != (offset_reg == '0))
                begin
                    offset_next  = '0;
                    asm_len_next = '0;
                    if (first_hdr)
                    begin
                        status = frag_reasm_pkg::ST_DROP_PREV;
                    end
                    else
                    begin
                        status       = frag_reasm_pkg::ST_DROP_FRAG;
                        discard_next = (remain_next != '0);
                        last_next    = 1'b0;
                    end
                end
                // Empty fragment ends at once
                if (status != frag_reasm_pkg::ST_DROP_FRAG && remain_next == '0)
                begin
                    asm_len_next = offset_next;
                    if (last_next)
                    begin
                        offset_next = '0;
                        status      = frag_reasm_pkg::ST_COMPLETE;
                    end
                end
            end
            frag_reasm_pkg::CMD_PAYLOAD:
            begin
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - 1'b1;
                    priority if (discard_reg)
                    begin
                        if (remain_next == '0)
                        begin
                            discard_next = 1'b0;
                        end
                    end
                    else if (offset_reg >= OW'(STORE_DEPTH))
                    begin
                        status       = frag_reasm_pkg::ST_OVERFLOW;
                        offset_next  = '0;
                        asm_len_next = '0;
                        last_next    = 1'b0;
                        discard_next = (remain_next != '0);
                    end
                    else
                    begin
                        wr_en        = accept;
                        offset_next  = offset_reg + 1'b1;
                        asm_len_next = offset_next;
                        status       = frag_reasm_pkg::ST_STORED;
                        if (remain_next == '0 && last_reg)
                        begin
                            offset_next = '0;
                            status      = frag_reasm_pkg::ST_COMPLETE;
                        end
                    end
                end
            end
            frag_reasm_pkg::CMD_READ:
            begin
                if (read_hit)
                begin
                    status = frag_reasm_pkg::ST_READ;
                    rd_en  = accept;
                end
            end
            frag_reasm_pkg::CMD_UNUSED:
            begin
                status = frag_reasm_pkg::ST_NOTHING;
            end
            default:
            begin
                status = frag_reasm_pkg::ST_NOTHING;
            end
        endcase
    end

    assign wr_addr = offset_reg[AW-1:0];
    assign wr_data = data_byte;
    assign rd_addr = index_ext[AW-1:0];

    // Result of this request; length wraps to the port width
    assign len_ext        = LW'(asm_len_next);
    assign result.status  = status;
    assign result.length  = len_ext[frag_reasm_pkg::MSG_LEN_W-1:0];
    assign result.is_read = (status == frag_reasm_pkg::ST_READ);

    // Advance the fragment state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            remain_reg  <= '0;
            last_reg    <= 1'b0;
            discard_reg <= 1'b0;
            asm_len_reg <= '0;
        end
        else if (accept)
        begin
            offset_reg  <= offset_next;
            remain_reg  <= remain_next;
            last_reg    <= last_next;
            discard_reg <= discard_next;
            asm_len_reg <= asm_len_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/frag_reasm_out.sv =====
// ============================================================================
// frag_reasm_out
// Result pipeline: a read stage waits for store read data, then the
// result is held in an output register until the sink takes it.
// ============================================================================
`default_nettype none

module frag_reasm_out (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   accept,
    input  wire frag_reasm_pkg::result_t                result,
    input  wire logic [frag_reasm_pkg::BYTE_W-1:0]      rd_data,
    output logic                                        in_ready,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic      [frag_reasm_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic                              s1_valid_reg;
    frag_reasm_pkg::result_t           s1_res_reg;
    logic                              out_valid_reg;
    logic [frag_reasm_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                              out_free;
    logic                              s1_move;
    logic [frag_reasm_pkg::BYTE_W-1:0] read_byte;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Read data only counts for read results
    assign read_byte = s1_res_reg.is_read ? rd_data : '0;

    // Track occupancy of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload of both stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= result;
        end
        if (s1_move)
        begin
            out_data_reg <= {{frag_reasm_pkg::OUT_PAD_W{1'b0}}, read_byte,
                             s1_res_reg.length, s1_res_reg.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fragment_reassembler_top.sv =====
// ============================================================================
// fragment_reassembler_top
// Rebuilds messages from header and payload byte requests into a byte store
// and answers reads of the assembled message.
// ============================================================================
//
//  Channel  Dir  Handshake           Content
//  s_*      in   s_tvalid/s_tready   command, data_byte, read_index
//  m_*      out  m_tvalid/m_tready   status, message_length, read_data
//
//  One request per cycle while s_tready is high. A result goes to m_*
//  through the read stage (control stage with store read) and then the
//  output register; the store takes one payload write or one read per cycle.
//  Reset clears offsets, lengths and flags; the store content is left as is.
//  A stalled sink holds the output register; one more request is still taken
//  into the read stage before s_tready drops.
//
`default_nettype none

module fragment_reassembler_top #(
    parameter int STORE_DEPTH = frag_reasm_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // [1:0] command, [9:2] data_byte, [17:10] read_index, rest zero
    input  wire logic [frag_reasm_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [2:0] status, [11:3] message_length, [19:12] read_data, rest zero
    output logic      [frag_reasm_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic                                    accept;
    logic [frag_reasm_pkg::CMD_W-1:0]        command;
    logic [frag_reasm_pkg::BYTE_W-1:0]       data_byte;
    logic [frag_reasm_pkg::INDEX_W-1:0]      read_index;
    frag_reasm_pkg::result_t                 result;
    logic                                    wr_en;
    logic [AW-1:0]                           wr_addr;
    logic [frag_reasm_pkg::BYTE_W-1:0]       wr_data;
    logic                                    rd_en;
    logic [AW-1:0]                           rd_addr;
    logic [frag_reasm_pkg::BYTE_W-1:0]       rd_data;

    // Unpack the request
    assign command    = s_tdata[1:0];
    assign data_byte  = s_tdata[9:2];
    assign read_index = s_tdata[17:10];
    assign accept     = s_tvalid && s_tready;

    frag_reasm_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .data_byte  (data_byte),
        .read_index (read_index),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    frag_reasm_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    frag_reasm_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .result   (result),
        .rd_data  (rd_data),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Store writes only for requests that report a stored byte
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (accept && (result.status == frag_reasm_pkg::ST_STORED ||
                              result.status == frag_reasm_pkg::ST_COMPLETE)))
        else $error("store write without stored status");

    // A read result always fetches from the store
    a_read_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.is_read) |-> rd_en)
        else $error("read result without store read");

    // Both stages full and sink stalled: take no request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && u_out.s1_valid_reg) |-> !s_tready)
        else $error("request taken while pipeline full");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the fragment reassembler. A directed table covers
// reset values, empty and dropped fragments and range checks of reads. It is
// followed by random messages built from small fragments, two full-store
// messages and some noise. Each accepted request is run through a shadow
// reassembler, and every result is compared with the oldest pending expectation.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH        = frag_reasm_pkg::STORE_DEPTH_DEF;
    localparam int DIR_N        = 21;
    localparam int RAND_ITEMS   = 630;
    localparam int QUIET_N      = 80;
    localparam int PAUSE_AT     = 450;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [frag_reasm_pkg::STATUS_W-1:0]  status;
        logic [frag_reasm_pkg::MSG_LEN_W-1:0] length;
        logic [frag_reasm_pkg::BYTE_W-1:0]    rdata;
    } reasm_result_t;

    typedef struct packed {
        logic                                 typed;
        reasm_result_t                        want;
        logic [frag_reasm_pkg::CMD_W-1:0]     cmd;
        logic [frag_reasm_pkg::BYTE_W-1:0]    dbyte;
        logic [frag_reasm_pkg::INDEX_W-1:0]   ridx;
    } frag_req_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   s_tvalid;
    logic                                   s_tready;
    logic [frag_reasm_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                                   m_tvalid;
    logic                                   m_tready;
    logic [frag_reasm_pkg::OUT_TDATA_W-1:0] m_tdata;

    frag_req_t     req_q[$];
    reasm_result_t pending_results[$];
    frag_req_t     offered;
    logic          quiet;
    int            accepted_reqs;
    int            idle_cycles;
    int            err_count;

    // Shadow state of the reassembler
    logic [frag_reasm_pkg::BYTE_W-1:0]    shadow_mem [DEPTH];
    logic [frag_reasm_pkg::MSG_LEN_W-1:0] fill_ptr;
    logic [frag_reasm_pkg::REM_W-1:0]     frag_left;
    logic                                 frag_last;
    logic                                 frag_skip;
    logic [frag_reasm_pkg::MSG_LEN_W-1:0] msg_len;

    fragment_reassembler_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Advance the shadow reassembler by one request and return its result
    function automatic reasm_result_t reasm_predict(
        input logic [frag_reasm_pkg::CMD_W-1:0]   cmd,
        input logic [frag_reasm_pkg::BYTE_W-1:0]  dbyte,
        input logic [frag_reasm_pkg::INDEX_W-1:0] ridx);
        reasm_result_t r;
        logic          hdr_first;
        r.status = frag_reasm_pkg::ST_NOTHING;
        r.rdata  = '0;
        case (cmd)
            frag_reasm_pkg::CMD_HEADER:
            begin
                hdr_first = dbyte[frag_reasm_pkg::HDR_FIRST_BIT];
                frag_left = dbyte[frag_reasm_pkg::REM_W-1:0];
                frag_last = dbyte[frag_reasm_pkg::HDR_LAST_BIT];
                frag_skip = 1'b0;
                // A first flag must coincide with an empty message
                if (hdr_first != (fill_ptr == '0))
                begin
                    fill_ptr = '0;
                    msg_len  = '0;
                    if (hdr_first)
                    begin
                        r.status = frag_reasm_pkg::ST_DROP_PREV;
                    end
                    else
                    begin
                        r.status  = frag_reasm_pkg::ST_DROP_FRAG;
                        frag_skip = (frag_left != '0);
                        frag_last = 1'b0;
                    end
                end
                // Close an empty fragment at once
                if (!frag_skip && r.status != frag_reasm_pkg::ST_DROP_FRAG &&
                    frag_left == '0)
                begin
                    msg_len = fill_ptr;
                    if (frag_last)
                    begin
                        fill_ptr = '0;
                        r.status = frag_reasm_pkg::ST_COMPLETE;
                    end
                end
            end
            frag_reasm_pkg::CMD_PAYLOAD:
            begin
                if (frag_left != '0)
                begin
                    frag_left = frag_left - 1'b1;
                    if (frag_skip)
                    begin
                        if (frag_left == '0)
                            frag_skip = 1'b0;
                    end
                    else if (fill_ptr >= DEPTH)
                    begin
                        r.status  = frag_reasm_pkg::ST_OVERFLOW;
                        fill_ptr  = '0;
                        msg_len   = '0;
                        frag_last = 1'b0;
                        frag_skip = (frag_left != '0);
                    end
                    else
                    begin
                        shadow_mem[fill_ptr] = dbyte;
                        fill_ptr = fill_ptr + 1'b1;
                        msg_len  = fill_ptr;
                        r.status = frag_reasm_pkg::ST_STORED;
                        if (frag_left == '0 && frag_last)
                        begin
                            fill_ptr = '0;
                            r.status = frag_reasm_pkg::ST_COMPLETE;
                        end
                    end
                end
            end
            frag_reasm_pkg::CMD_READ:
            begin
                if (ridx < msg_len)
                begin
                    r.rdata  = shadow_mem[ridx];
                    r.status = frag_reasm_pkg::ST_READ;
                end
            end
            default:
            begin
            end
        endcase
        r.length = msg_len;
        return r;
    endfunction

    // Directed requests; typed expectations only where they are obvious
    function automatic frag_req_t directed_row(input int i);
        case (i)
            0:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_READ, 8'h00, 8'h00};
            1:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_UNUSED, 8'hFF, 8'hFF};
            2:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'hAA, 8'h00};
            3:  return {1'b1, frag_reasm_pkg::ST_DROP_FRAG, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'h03, 8'h00};
            4:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'h11, 8'h00};
            5:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'h22, 8'h00};
            6:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'h33, 8'h00};
            7:  return {1'b1, frag_reasm_pkg::ST_COMPLETE, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'hC0, 8'h00};
            8:  return {1'b1, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'h42, 8'h00};
            9:  return {1'b1, frag_reasm_pkg::ST_STORED, 9'd1, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'h00, 8'h00};
            10: return {1'b1, frag_reasm_pkg::ST_STORED, 9'd2, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'hFF, 8'h00};
            11: return {1'b1, frag_reasm_pkg::ST_DROP_PREV, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'h41, 8'h00};
            12: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'h5A, 8'h00};
            13: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'h83, 8'h00};
            14: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_PAYLOAD, 8'h01, 8'h00};
            15: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'h80, 8'h00};
            16: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_READ, 8'h00, 8'h01};
            17: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_READ, 8'h00, 8'h02};
            18: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_READ, 8'hFF, 8'hFF};
            19: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                        frag_reasm_pkg::CMD_HEADER, 8'h3F, 8'h00};
            default: return {1'b0, frag_reasm_pkg::ST_NOTHING, 9'd0, 8'h00,
                             frag_reasm_pkg::CMD_HEADER, 8'hFF, 8'h00};
        endcase
    endfunction

    // Queue one request that is checked against the shadow reassembler
    task automatic add_req(input logic [frag_reasm_pkg::CMD_W-1:0] cmd,
                           input logic [frag_reasm_pkg::BYTE_W-1:0] dbyte,
                           input logic [frag_reasm_pkg::INDEX_W-1:0] ridx);
        frag_req_t r;
        r.typed = 1'b0;
        r.want  = '0;
        r.cmd   = cmd;
        r.dbyte = dbyte;
        r.ridx  = ridx;
        req_q.push_back(r);
    endtask

    // Queue a header followed by a number of payload bytes
    task automatic add_fragment(input logic mark_first, input logic is_last,
                                input int flen, input int npay);
        logic [frag_reasm_pkg::BYTE_W-1:0] hdr;
        hdr = 8'(flen);
        hdr[frag_reasm_pkg::HDR_FIRST_BIT] = mark_first;
        hdr[frag_reasm_pkg::HDR_LAST_BIT]  = is_last;
        add_req(frag_reasm_pkg::CMD_HEADER, hdr, 8'($urandom_range(0, 255)));
        repeat (npay)
            add_req(frag_reasm_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    endtask

    // Report a failed comparison
    task automatic flag_error(input string what, input reasm_result_t want,
                              input reasm_result_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t %s: expected st %0d len %0d data %02h, got st %0d len %0d data %02h",
                     $realtime, what, want.status, want.length, want.rdata,
                     got.status, got.length, got.rdata);
    endtask

    // Predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : monitor
        reasm_result_t predicted;
        reasm_result_t got;
        reasm_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = reasm_predict(offered.cmd, offered.dbyte, offered.ridx);
                pending_results.push_back(offered.typed ? offered.want : predicted);
                accepted_reqs++;
            end
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[frag_reasm_pkg::STATUS_W-1:0];
                got.length = m_tdata[frag_reasm_pkg::STATUS_W +: frag_reasm_pkg::MSG_LEN_W];
                got.rdata  = m_tdata[frag_reasm_pkg::STATUS_W + frag_reasm_pkg::MSG_LEN_W +:
                                     frag_reasm_pkg::BYTE_W];
                if (pending_results.size() == 0)
                begin
                    flag_error("unexpected result", '0, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.length !== want.length ||
                        got.rdata !== want.rdata)
                        flag_error("mismatch", want, got);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Stall the result side: short random bursts plus one long hold-off
    initial
    begin : sink
        int  stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!hold_done && accepted_reqs >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready   = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready   = 1'b0;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Build the stimulus, reset, drive the requests and close the run
    initial
    begin : driver
        int   i;
        int   k;
        int   f;
        int   nfrag;
        int   flen;
        int   npay;
        int   total;
        int   n;
        logic placed_full;
        logic placed_over;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        offered       = '0;
        quiet         = 1'b0;
        accepted_reqs = 0;
        err_count     = 0;
        fill_ptr      = '0;
        frag_left     = '0;
        frag_last     = 1'b0;
        frag_skip     = 1'b0;
        msg_len       = '0;
        placed_full   = 1'b0;
        placed_over   = 1'b0;
        for (i = 0; i < DEPTH; i++)
            shadow_mem[i] = '0;

        for (i = 0; i < DIR_N; i++)
            req_q.push_back(directed_row(i));

        while (req_q.size() < DIR_N + RAND_ITEMS)
        begin
            k = $urandom_range(0, 99);
            if (!placed_full && req_q.size() > 40)
            begin
                // Fill the store exactly, then read it back at random
                placed_full = 1'b1;
                for (f = 0; f < 5; f++)
                    add_fragment(f == 0, f == 4, (f == 4) ? 4 : 63, (f == 4) ? 4 : 63);
                repeat (4)
                    add_req(frag_reasm_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            end
            else if (!placed_over && req_q.size() > 300)
            begin
                // Run past the end of the store
                placed_over = 1'b1;
                for (f = 0; f < 5; f++)
                    add_fragment(f == 0, f == 4, 63, 63);
                add_req(frag_reasm_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
            end
            else if (k < 88)
            begin
                // Mostly well-formed messages; some miss the first or last flag
                nfrag = $urandom_range(1, 4);
                total = 0;
                for (f = 0; f < nfrag; f++)
                begin
                    flen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 8);
                    npay = flen;
                    n    = $urandom_range(0, 9);
                    if (n == 0)
                        npay = flen + $urandom_range(1, 3);
                    else if (n == 1 && flen > 0)
                        npay = $urandom_range(0, flen - 1);
                    add_fragment((f == 0) && !(k >= 70 && k < 80),
                                 (f == nfrag - 1) && (k < 80), flen, npay);
                    total += flen;
                end
                repeat ($urandom_range(1, 4))
                    add_req(frag_reasm_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                            : 8'($urandom_range(0, (total < 253) ? total + 2 : 255)));
            end
            else
            begin
                // Noise: random headers, stray payload, unused and random reads
                case ($urandom_range(0, 3))
                    0:
                    begin
                        add_req(frag_reasm_pkg::CMD_HEADER, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                        repeat ($urandom_range(0, 6))
                            add_req(frag_reasm_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
                    end
                    1: add_req(frag_reasm_pkg::CMD_UNUSED, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                    2: add_req(frag_reasm_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                    default: add_req(frag_reasm_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
                endcase
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < req_q.size(); i++)
        begin
            quiet = (i >= req_q.size() - QUIET_N);
            if (i == PAUSE_AT)
            begin
                // Hold off until every result is back
                if (pending_results.size() != 0)
                begin
                    s_tvalid = 1'b0;
                    while (pending_results.size() != 0)
                        @(negedge clk);
                end
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            // Offer the request and wait for the handshake
            offered  = req_q[i];
            s_tdata  = {{(frag_reasm_pkg::IN_TDATA_W - frag_reasm_pkg::CMD_W -
                          frag_reasm_pkg::BYTE_W - frag_reasm_pkg::INDEX_W){1'b0}},
                        offered.ridx, offered.dbyte, offered.cmd};
            s_tvalid = 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
        end
        s_tvalid = 1'b0;

        // Drain the outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
